### rtl/core/sfpp_pkg.sv
`timescale 1ns / 1ps

package sfpp_pkg;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_ID      = 4'd2,
    PH_LEN_LO  = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_CHK = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHKSUM  = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } phase_t;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ID_A        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID_B        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ID_C        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ID_D        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ID_E        = 3'd6;

  localparam logic [7:0] RST_FIRST_SYNC  = 8'hAA;
  localparam logic [7:0] RST_SECOND_SYNC = 8'h55;
  localparam logic [7:0] RST_ID_A        = 8'd1;
  localparam logic [7:0] RST_ID_B        = 8'd2;
  localparam logic [7:0] RST_ID_C        = 8'd3;
  localparam logic [7:0] RST_ID_D        = 8'd4;
  localparam logic [7:0] RST_ID_E        = 8'd5;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  frame_id;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [1:0]  status;
  } result_t;

endpackage

### rtl/core/sync_framed_packet_parser_top.sv
`timescale 1ns / 1ps

// Channel   Direction  tdata / data                         tuser / index
// s_axis    in         [7:0] data_byte                      [0] cmd
// m_axis    out        [7:0] payload_byte, [23:8]           [1:0] status,
//                      payload_index, [31:24] frame_id,     [2] payload_valid
//                      [47:32] frame_length
// cfg       in         [7:0] cfg_data                       [2:0] cfg_index
//
// One input transaction per cycle while s_axis_tready is high; its result is
// registered on acceptance. The parse state is updated in the accept cycle.
// A skid register holds one result while m_axis stalls; s_axis_tready drops
// only when that skid register is full. rst (synchronous) returns the parser
// to the first sync byte and the configuration registers to their defaults.

module sync_framed_packet_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload_byte, payload_index, frame_id, frame_length
  output logic [2:0]  m_axis_tuser,   // status, payload_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sfpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] id_a;
  logic [7:0] id_b;
  logic [7:0] id_c;
  logic [7:0] id_d;
  logic [7:0] id_e;

  sfpp_pkg::phase_t phase;
  sfpp_pkg::phase_t phase_next;
  logic [7:0]  held_id;
  logic [7:0]  held_id_next;
  logic [15:0] declared_length;
  logic [15:0] declared_length_next;
  logic [7:0]  length_check;
  logic [7:0]  length_check_next;
  logic [15:0] byte_position;
  logic [15:0] byte_position_next;
  logic [7:0]  running_xor;
  logic [7:0]  running_xor_next;

  sfpp_pkg::result_t result;
  sfpp_pkg::result_t out_reg;
  sfpp_pkg::result_t skid_reg;
  logic              out_valid;
  logic              skid_valid;

  logic       in_accept;
  logic       out_free;
  logic       take_xor;
  logic       id_ok;
  logic       last_payload;
  logic [7:0] b;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign b             = s_axis_tdata;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.frame_length, out_reg.frame_id,
                          out_reg.payload_index, out_reg.payload_byte};
  assign m_axis_tuser  = {out_reg.payload_valid, out_reg.status};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= sfpp_pkg::RST_FIRST_SYNC;
      second_sync <= sfpp_pkg::RST_SECOND_SYNC;
      id_a        <= sfpp_pkg::RST_ID_A;
      id_b        <= sfpp_pkg::RST_ID_B;
      id_c        <= sfpp_pkg::RST_ID_C;
      id_d        <= sfpp_pkg::RST_ID_D;
      id_e        <= sfpp_pkg::RST_ID_E;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfpp_pkg::REG_FIRST_SYNC:  first_sync  <= cfg_data;
        sfpp_pkg::REG_SECOND_SYNC: second_sync <= cfg_data;
        sfpp_pkg::REG_ID_A:        id_a        <= cfg_data;
        sfpp_pkg::REG_ID_B:        id_b        <= cfg_data;
        sfpp_pkg::REG_ID_C:        id_c        <= cfg_data;
        sfpp_pkg::REG_ID_D:        id_d        <= cfg_data;
        sfpp_pkg::REG_ID_E:        id_e        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign id_ok = (b == id_a) || (b == id_b) || (b == id_c) || (b == id_d) || (b == id_e);
  assign last_payload = (declared_length == 16'd0) ||
                        (({1'b0, byte_position} + 17'd1) >= {1'b0, declared_length});

  // next state
  always_comb begin
    phase_next           = phase;
    held_id_next         = held_id;
    declared_length_next = declared_length;
    length_check_next    = length_check;
    byte_position_next   = byte_position;
    running_xor_next     = running_xor;
    take_xor             = 1'b1;
    if (s_axis_tuser == sfpp_pkg::CMD_RESTART) begin
      phase_next           = sfpp_pkg::PH_SYNC1;
      held_id_next         = '0;
      declared_length_next = '0;
      length_check_next    = '0;
      byte_position_next   = '0;
      running_xor_next     = '0;
    end else begin
      unique case (phase)
        sfpp_pkg::PH_SYNC1:
          phase_next = (b == first_sync) ? sfpp_pkg::PH_SYNC2 : sfpp_pkg::PH_ERROR;
        sfpp_pkg::PH_SYNC2:
          phase_next = (b == second_sync) ? sfpp_pkg::PH_ID : sfpp_pkg::PH_ERROR;
        sfpp_pkg::PH_ID: begin
          if (id_ok) begin
            held_id_next = b;
            phase_next   = sfpp_pkg::PH_LEN_LO;
          end else begin
            phase_next   = sfpp_pkg::PH_ERROR;
          end
        end
        sfpp_pkg::PH_LEN_LO: begin
          declared_length_next = {8'd0, b};
          length_check_next    = b;
          phase_next           = sfpp_pkg::PH_LEN_HI;
        end
        sfpp_pkg::PH_LEN_HI: begin
          declared_length_next = {b, declared_length[7:0]};
          length_check_next    = length_check ^ b;
          phase_next           = sfpp_pkg::PH_LEN_CHK;
        end
        sfpp_pkg::PH_LEN_CHK:
          phase_next = (b == length_check) ? sfpp_pkg::PH_PAYLOAD : sfpp_pkg::PH_ERROR;
        sfpp_pkg::PH_PAYLOAD: begin
          if (last_payload) begin
            phase_next = sfpp_pkg::PH_CHKSUM;
          end
          byte_position_next = byte_position + 16'd1;
        end
        sfpp_pkg::PH_CHKSUM: begin
          phase_next = (b == running_xor) ? sfpp_pkg::PH_DONE : sfpp_pkg::PH_ERROR;
          take_xor   = 1'b0;
        end
        sfpp_pkg::PH_DONE:
          take_xor = 1'b0;
        default: begin
          phase_next = sfpp_pkg::PH_ERROR;
          take_xor   = 1'b0;
        end
      endcase
      if (take_xor && (phase_next != sfpp_pkg::PH_ERROR)) begin
        running_xor_next = running_xor ^ b;
      end
    end
  end

  // result fields
  always_comb begin
    result               = '0;
    result.frame_id      = held_id_next;
    result.frame_length  = declared_length_next;
    if (phase_next == sfpp_pkg::PH_DONE) begin
      result.status = sfpp_pkg::ST_DONE;
    end else if (phase_next == sfpp_pkg::PH_ERROR) begin
      result.status = sfpp_pkg::ST_ERROR;
    end else begin
      result.status = sfpp_pkg::ST_BUSY;
    end
    if ((s_axis_tuser == sfpp_pkg::CMD_BYTE) && (phase == sfpp_pkg::PH_PAYLOAD)) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = b;
      result.payload_index = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sfpp_pkg::PH_SYNC1;
      held_id         <= '0;
      declared_length <= '0;
      length_check    <= '0;
      byte_position   <= '0;
      running_xor     <= '0;
    end else if (in_accept) begin
      phase           <= phase_next;
      held_id         <= held_id_next;
      declared_length <= declared_length_next;
      length_check    <= length_check_next;
      byte_position   <= byte_position_next;
      running_xor     <= running_xor_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || in_accept;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_accept) begin
        out_reg <= result;
      end
    end else if (in_accept) begin
      skid_reg <= result;
    end
  end

endmodule

### test/sync_framed_packet_parser_top_tb.sv
`timescale 1ns / 1ps

module sync_framed_packet_parser_top_tb;

  localparam logic [sfpp_pkg::CFG_IDX_W-1:0] REG_ORDER [7] = '{
    sfpp_pkg::REG_FIRST_SYNC, sfpp_pkg::REG_SECOND_SYNC, sfpp_pkg::REG_ID_A,
    sfpp_pkg::REG_ID_B, sfpp_pkg::REG_ID_C, sfpp_pkg::REG_ID_D, sfpp_pkg::REG_ID_E
  };

  class frame_scoreboard;
    logic [7:0]         regs [7];
    sfpp_pkg::phase_t   ph;
    logic [7:0]         cur_id;
    logic [15:0]        cur_len;
    logic [7:0]         len_sum;
    logic [15:0]        pos;
    logic [7:0]         xsum;
    sfpp_pkg::result_t  want_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned completes;
    int unsigned faults;
    int unsigned payloads;

    function new();
      regs[sfpp_pkg::REG_FIRST_SYNC]  = sfpp_pkg::RST_FIRST_SYNC;
      regs[sfpp_pkg::REG_SECOND_SYNC] = sfpp_pkg::RST_SECOND_SYNC;
      regs[sfpp_pkg::REG_ID_A]        = sfpp_pkg::RST_ID_A;
      regs[sfpp_pkg::REG_ID_B]        = sfpp_pkg::RST_ID_B;
      regs[sfpp_pkg::REG_ID_C]        = sfpp_pkg::RST_ID_C;
      regs[sfpp_pkg::REG_ID_D]        = sfpp_pkg::RST_ID_D;
      regs[sfpp_pkg::REG_ID_E]        = sfpp_pkg::RST_ID_E;
      clear_parse();
    endfunction

    function void clear_parse();
      ph      = sfpp_pkg::PH_SYNC1;
      cur_id  = '0;
      cur_len = '0;
      len_sum = '0;
      pos     = '0;
      xsum    = '0;
    endfunction

    function void set_reg(input logic [sfpp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
      regs[idx] = val;
    endfunction

    function void note_input(input logic c, input logic [7:0] b);
      sfpp_pkg::result_t r;
      logic              fold;
      logic              id_ok;
      sfpp_pkg::phase_t  prev;
      int                k;
      r    = '0;
      fold = 1'b1;
      prev = ph;
      if (c == sfpp_pkg::CMD_RESTART) begin
        clear_parse();
      end else begin
        case (ph)
          sfpp_pkg::PH_SYNC1: begin
            ph = (b == regs[sfpp_pkg::REG_FIRST_SYNC]) ? sfpp_pkg::PH_SYNC2
                                                       : sfpp_pkg::PH_ERROR;
          end
          sfpp_pkg::PH_SYNC2: begin
            ph = (b == regs[sfpp_pkg::REG_SECOND_SYNC]) ? sfpp_pkg::PH_ID
                                                        : sfpp_pkg::PH_ERROR;
          end
          sfpp_pkg::PH_ID: begin
            id_ok = 1'b0;
            for (k = sfpp_pkg::REG_ID_A; k <= sfpp_pkg::REG_ID_E; k++) begin
              if (regs[k] == b) id_ok = 1'b1;
            end
            if (id_ok) begin
              cur_id = b;
              ph     = sfpp_pkg::PH_LEN_LO;
            end else begin
              ph = sfpp_pkg::PH_ERROR;
            end
          end
          sfpp_pkg::PH_LEN_LO: begin
            cur_len = {8'h00, b};
            len_sum = b;
            ph      = sfpp_pkg::PH_LEN_HI;
          end
          sfpp_pkg::PH_LEN_HI: begin
            cur_len = {b, cur_len[7:0]};
            len_sum = len_sum ^ b;
            ph      = sfpp_pkg::PH_LEN_CHK;
          end
          sfpp_pkg::PH_LEN_CHK: begin
            ph = (b == len_sum) ? sfpp_pkg::PH_PAYLOAD : sfpp_pkg::PH_ERROR;
          end
          sfpp_pkg::PH_PAYLOAD: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = pos;
            payloads++;
            if (cur_len == 16'd0 || (32'(pos) + 1) >= 32'(cur_len)) ph = sfpp_pkg::PH_CHKSUM;
            pos = pos + 16'd1;
          end
          sfpp_pkg::PH_CHKSUM: begin
            ph   = (b == xsum) ? sfpp_pkg::PH_DONE : sfpp_pkg::PH_ERROR;
            fold = 1'b0;
          end
          sfpp_pkg::PH_DONE: begin
            fold = 1'b0;
          end
          default: begin
            ph   = sfpp_pkg::PH_ERROR;
            fold = 1'b0;
          end
        endcase
        if (fold && ph != sfpp_pkg::PH_ERROR) xsum = xsum ^ b;
      end
      if (ph == sfpp_pkg::PH_ERROR && prev != sfpp_pkg::PH_ERROR) faults++;
      if (ph == sfpp_pkg::PH_DONE && prev != sfpp_pkg::PH_DONE) completes++;
      case (ph)
        sfpp_pkg::PH_DONE:  r.status = sfpp_pkg::ST_DONE;
        sfpp_pkg::PH_ERROR: r.status = sfpp_pkg::ST_ERROR;
        default:            r.status = sfpp_pkg::ST_BUSY;
      endcase
      r.frame_id     = cur_id;
      r.frame_length = cur_len;
      want_q.push_back(r);
    endfunction

    function void cmp(input string tag, input int unsigned want, input int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 20)
          $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
      end
    endfunction

    function void check_result(input sfpp_pkg::result_t got);
      sfpp_pkg::result_t want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected result, expected none actual %0h", $time, got);
      end else begin
        want = want_q.pop_front();
        checked++;
        cmp("status", want.status, got.status);
        cmp("payload_valid", want.payload_valid, got.payload_valid);
        cmp("payload_byte", want.payload_byte, got.payload_byte);
        cmp("payload_index", want.payload_index, got.payload_index);
        cmp("frame_id", want.frame_id, got.frame_id);
        cmp("frame_length", want.frame_length, got.frame_length);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic                           s_axis_tuser = sfpp_pkg::CMD_BYTE;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [47:0]                    m_axis_tdata;
  logic [2:0]                     m_axis_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [sfpp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data = '0;

  frame_scoreboard   sb = new();
  sfpp_pkg::result_t seen;
  logic [7:0]        setting [7];
  bit                steady = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       taken = 0;

  sync_framed_packet_parser_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status        = m_axis_tuser[1:0];
      seen.payload_valid = m_axis_tuser[2];
      seen.payload_byte  = m_axis_tdata[7:0];
      seen.payload_index = m_axis_tdata[23:8];
      seen.frame_id      = m_axis_tdata[31:24];
      seen.frame_length  = m_axis_tdata[47:32];
      sb.check_result(seen);
    end
  end

  // receiver: random stalls, one long hold to back up the input side
  initial begin : result_sink
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (!rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (taken == 250 && !held) begin
        held  = 1'b1;
        stall = 150;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= c;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(c, b);
    items_sent++;
  endtask

  // build a frame from the current settings; optionally flip one byte,
  // cut it short, and append trailing bytes
  task automatic send_frame(input int unsigned plen, input int bad_at,
                            input int unsigned cut, input int unsigned extras);
    logic [7:0]  fb [$];
    logic [7:0]  sum;
    int unsigned n;
    int unsigned i;
    fb.push_back(sb.regs[sfpp_pkg::REG_FIRST_SYNC]);
    fb.push_back(sb.regs[sfpp_pkg::REG_SECOND_SYNC]);
    fb.push_back(sb.regs[sfpp_pkg::REG_ID_A + $urandom_range(0, 4)]);
    fb.push_back(plen[7:0]);
    fb.push_back(plen[15:8]);
    fb.push_back(plen[7:0] ^ plen[15:8]);
    n = (plen == 0) ? 1 : plen;
    repeat (n) fb.push_back(8'($urandom));
    sum = '0;
    foreach (fb[j]) sum = sum ^ fb[j];
    fb.push_back(sum);
    if (bad_at >= 0) begin
      if (bad_at >= fb.size()) bad_at = fb.size() - 1;
      fb[bad_at] = fb[bad_at] ^ 8'($urandom_range(1, 255));
    end
    if (cut == 0 || cut > fb.size()) cut = fb.size();
    for (i = 0; i < cut; i++) send_item(sfpp_pkg::CMD_BYTE, fb[i]);
    repeat (extras) send_item(sfpp_pkg::CMD_BYTE, 8'($urandom));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs();
    int k;
    for (k = 0; k < $size(REG_ORDER); k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[k];
      cfg_data  <= setting[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(REG_ORDER[k], setting[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned plen;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      pick   = $urandom_range(0, 99);
      plen   = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 520) : $urandom_range(0, 6);
      if (pick < 70) begin
        send_item(sfpp_pkg::CMD_RESTART, 8'($urandom));
        send_frame(plen, -1, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 90) begin
        send_item(sfpp_pkg::CMD_RESTART, 8'($urandom));
        send_frame(plen, $urandom_range(0, plen + 7),
                   $urandom_range(0, 1) ? 0 : $urandom_range(1, plen + 7),
                   $urandom_range(0, 2));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(($urandom_range(0, 9) == 0) ? sfpp_pkg::CMD_RESTART : sfpp_pkg::CMD_BYTE,
                    8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_frame(0, -1, 0, 1);
    send_item(sfpp_pkg::CMD_RESTART, 8'hFF);
    send_item(sfpp_pkg::CMD_BYTE, 8'h00);
    send_item(sfpp_pkg::CMD_RESTART, 8'h00);
    send_item(sfpp_pkg::CMD_BYTE, sb.regs[sfpp_pkg::REG_FIRST_SYNC]);
    send_item(sfpp_pkg::CMD_BYTE, sb.regs[sfpp_pkg::REG_SECOND_SYNC]);
    send_item(sfpp_pkg::CMD_BYTE, 8'hFF);
    send_item(sfpp_pkg::CMD_RESTART, 8'h5A);
    send_frame(1, 5, 7, 0);
    send_item(sfpp_pkg::CMD_RESTART, 8'hA5);
    send_frame(0, 99, 0, 0);
    settle();

    setting = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00};
    write_regs();
    run_traffic(370);
    settle();

    setting = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    write_regs();
    run_traffic(370);
    settle();

    for (k = 0; k < 7; k++) setting[k] = 8'($urandom);
    write_regs();
    run_traffic(370);
    settle();

    for (k = 0; k < 7; k++) setting[k] = 8'($urandom);
    write_regs();
    run_traffic(370);

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes over five register settings; %0d results compared.",
             items_sent, sb.checked);
    $display("Frames completed %0d, parse errors %0d, payload bytes %0d.",
             sb.completes, sb.faults, sb.payloads);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
